@@ hdl/pcst_pkg.sv @@
`timescale 1ns / 1ps
package pcst_pkg;
  // operation codes on the request stream
  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_QUERY  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RESYNC = 2'd1;
  localparam logic [1:0] ST_NOREF  = 2'd2;
  // register indexes
  localparam logic [1:0] REG_TICK_WRAP = 2'd0;
  localparam logic [1:0] REG_USEC_TICK = 2'd1;
  localparam logic [1:0] REG_RATE_ERR  = 2'd2;
  localparam logic [1:0] REG_RESET_US  = 2'd3;
  // magnitude saturation limit, 2^62-1
  localparam logic [63:0] MAG_SAT = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam int MUL_STEPS = 48;
  localparam int OUT_W = 104;
endpackage

@@ hdl/passive_clock_sync_tracker.sv @@
`timescale 1ns / 1ps
// Steps per query or referenced update: setup, 48-step multiply, check, 48-step multiply,
// finish, output load; an update that resyncs at the check skips to the output load; other
// requests go from setup to the output load. One request at a time: the next one is accepted
// in the cycle after the result loads.
// One result register decouples the output; a new request may enter while it waits.
// Reset (rst_ni low, asynchronous): registers to defaults, no reference held.
module passive_clock_sync_tracker #(
  parameter int TICK_BITS = 48,
  parameter int FRAC_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  // fields from bit 0: func[2], host_usec[63], dev_ticks[TICK_BITS], zero pad
  input  logic [((65+TICK_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fields from bit 0: status[2], host_estimate[64], sync_error[32], zero pad
  output logic [pcst_pkg::OUT_W-1:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import pcst_pkg::*;

  localparam int CW = $clog2(MUL_STEPS+1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // configuration registers
  logic [48:0] wrap_q;
  logic [47:0] upt_q;
  logic [31:0] rate_q;
  logic [39:0] rst_us_q;

  // tracker state
  logic [TICK_BITS-1:0] prev_q;
  logic [63:0] off_q, ref_dev_q, ref_host_q;
  logic        ref_valid_q;

  // request and working registers
  logic [2:0]  state_q;
  logic [1:0]  func_q;
  logic [62:0] host_q;
  logic [TICK_BITS-1:0] dev_q;
  logic [63:0] pi_q, dp_q, dq_q;
  logic        neg_q;

  // bit-serial multiplier: A parallel, B shifted out one bit a cycle
  logic [63:0] mul_a_q, acc_q;
  logic [47:0] mul_b_q, lo_q;
  logic [CW-1:0] cnt_q;

  // result register
  logic [1:0]  res_st_q;
  logic [63:0] res_est_q;
  logic [31:0] res_err_q;
  logic        out_v_q;
  logic [OUT_W-1:0] out_q;

  logic in_acc, cfg_wr, out_free;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid & s_axis_tready;
  assign out_free = ~out_v_q | m_axis_tready;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  always_comb begin
    unique case (paddr[4:3])
      REG_TICK_WRAP: prdata = {15'd0, wrap_q};
      REG_USEC_TICK: prdata = {16'd0, upt_q};
      REG_RATE_ERR:  prdata = {32'd0, rate_q};
      default:       prdata = {24'd0, rst_us_q};
    endcase
  end

  // multiplier step and saturated result
  logic [64:0]  mul_sum;
  logic [111:0] prod_sh;
  logic [63:0]  mul_res;
  assign mul_sum = {1'b0, acc_q} + (mul_b_q[0] ? {1'b0, mul_a_q} : 65'd0);
  assign prod_sh = {acc_q, lo_q} >> FRAC_BITS;
  assign mul_res = (|prod_sh[111:62]) ? MAG_SAT : prod_sh[63:0];

  // tick unwrapping
  logic [63:0] dev_x, wrap_x, off_n, pi_upd, pi_qry, pi_sel, d_sel;
  assign dev_x  = {{(64-TICK_BITS){1'b0}}, dev_q};
  assign wrap_x = {15'd0, wrap_q};
  assign off_n  = off_q + ((dev_q < prev_q) ? wrap_x : 64'd0);
  assign pi_upd = off_n + dev_x;
  assign pi_qry = off_q + dev_x - ((dev_q > prev_q) ? wrap_x : 64'd0);
  assign pi_sel = (func_q == FUNC_UPDATE) ? pi_upd : pi_qry;
  assign d_sel  = pi_sel - ref_dev_q;

  // compare of scaled delta against host delta
  logic [63:0] dp_n, dq_n, err_n;
  logic [64:0] diff;
  assign dp_n = neg_q ? (~mul_res + 64'd1) : mul_res;
  assign dq_n = {1'b0, host_q} - ref_host_q;
  assign diff = {dp_n[63], dp_n} - {dq_n[63], dq_n};
  assign err_n = diff[64] ? (~diff[63:0] + 64'd1) : diff[63:0];

  // finish: acceptance test and saturated estimate
  logic [64:0] adopt_s, e1_s, e2_s;
  logic [63:0] e1, e2;
  assign adopt_s = {dp_q[63], dp_q} + {1'b0, mul_res};
  assign e1_s = {ref_host_q[63], ref_host_q} + {dp_q[63], dp_q};
  assign e1 = (e1_s[64] != e1_s[63]) ? {e1_s[64], {63{~e1_s[64]}}} : e1_s[63:0];
  assign e2_s = {e1[63], e1} + {1'b0, mul_res};
  assign e2 = (e2_s[64] != e2_s[63]) ? {e2_s[64], {63{~e2_s[64]}}} : e2_s[63:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 49'd4294967296;
      upt_q <= 48'd4294967296;
      rate_q <= 32'd429497;
      rst_us_q <= 40'd500000;
      prev_q <= '0;
      off_q <= '0;
      ref_dev_q <= '0;
      ref_host_q <= '0;
      ref_valid_q <= 1'b0;
      state_q <= S_IDLE;
      cnt_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[4:3])
          REG_TICK_WRAP: wrap_q <= pwdata[48:0];
          REG_USEC_TICK: upt_q <= pwdata[47:0];
          REG_RATE_ERR:  rate_q <= pwdata[31:0];
          default:       rst_us_q <= pwdata[39:0];
        endcase
      end
      if (m_axis_tready) out_v_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) state_q <= S_PREP;
        end
        S_PREP: begin
          res_st_q <= ST_OK;
          res_est_q <= '0;
          res_err_q <= '0;
          pi_q <= pi_sel;
          neg_q <= d_sel[63];
          mul_a_q <= d_sel[63] ? (~d_sel + 64'd1) : d_sel;
          mul_b_q <= upt_q;
          acc_q <= '0;
          cnt_q <= CW'(MUL_STEPS);
          state_q <= S_MUL1;
          unique case (func_q)
            FUNC_UPDATE: begin
              off_q <= off_n;
              prev_q <= dev_q;
              if (!ref_valid_q) begin
                ref_dev_q <= pi_upd;
                ref_host_q <= {1'b0, host_q};
                ref_valid_q <= 1'b1;
                res_st_q <= ST_RESYNC;
                cnt_q <= '0;
                state_q <= S_OUT;
              end
            end
            FUNC_QUERY: begin
              if (!ref_valid_q) begin
                res_st_q <= ST_NOREF;
                cnt_q <= '0;
                state_q <= S_OUT;
              end
            end
            default: begin
              if (func_q == FUNC_CLEAR) ref_valid_q <= 1'b0;
              cnt_q <= '0;
              state_q <= S_OUT;
            end
          endcase
        end
        S_MUL1, S_MUL2: begin
          acc_q <= mul_sum[64:1];
          lo_q <= {mul_sum[0], lo_q[47:1]};
          mul_b_q <= {1'b0, mul_b_q[47:1]};
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) state_q <= (state_q == S_MUL1) ? S_CHK : S_FIN;
        end
        S_CHK: begin
          dp_q <= dp_n;
          dq_q <= dq_n;
          mul_a_q <= mul_res;
          mul_b_q <= {16'd0, rate_q};
          acc_q <= '0;
          cnt_q <= CW'(MUL_STEPS);
          state_q <= S_MUL2;
          if (func_q == FUNC_UPDATE) begin
            res_err_q <= (|err_n[63:32]) ? 32'hFFFF_FFFF : err_n[31:0];
            if (err_n >= {24'd0, rst_us_q}) begin
              ref_dev_q <= pi_q;
              ref_host_q <= {1'b0, host_q};
              res_st_q <= ST_RESYNC;
              cnt_q <= '0;
              state_q <= S_OUT;
            end
          end
        end
        S_FIN: begin
          if (func_q == FUNC_UPDATE) begin
            if ($signed(adopt_s) >= $signed({dq_q[63], dq_q})) begin
              ref_dev_q <= pi_q;
              ref_host_q <= {1'b0, host_q};
            end
          end else begin
            res_est_q <= e2;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_v_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= s_axis_tdata[1:0];
      host_q <= s_axis_tdata[64:2];
      dev_q <= s_axis_tdata[65+TICK_BITS-1:65];
    end
    if (state_q == S_OUT && out_free)
      out_q <= {{(OUT_W-98){1'b0}}, res_err_q, res_est_q, res_st_q};
  end

  // the step counter runs only inside a multiply
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (state_q == S_MUL1 || state_q == S_MUL2))
    else $error("multiplier counter live outside a multiply");
  // an accepted request is set up in the next cycle
  a_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_PREP))
    else $error("accepted request not set up");
  // a result is loaded only when leaving the output state
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_v_q)) |-> ($past(state_q) == S_OUT))
    else $error("result appeared without a finished request");
endmodule

@@ tb/sv/tb_passive_clock_sync_tracker.sv @@
`timescale 1ns / 1ps
module tb_passive_clock_sync_tracker;
  import pcst_pkg::*;

  // expected result of one request
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] host_est;
    logic [31:0] sync_err;
  } sync_result_t;

  // Tracks the sync state and configuration, and holds the results still due.
  class sync_scoreboard;
    logic [48:0] tick_wrap;
    logic [47:0] usec_per_tick;
    logic [31:0] rate_err;
    logic [39:0] reset_us;
    logic [47:0] last_ticks;
    logic [63:0] tick_offset;
    logic [63:0] anchor_ticks;
    logic [63:0] anchor_host;
    bit          anchored;
    sync_result_t due_q[$];
    int          errors;

    function void restart();
      tick_wrap = 49'h1_0000_0000;
      usec_per_tick = 48'h1_0000_0000;
      rate_err = 32'd429497;
      reset_us = 40'd500000;
      last_ticks = '0;
      tick_offset = '0;
      anchor_ticks = '0;
      anchor_host = '0;
      anchored = 0;
      due_q.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        REG_TICK_WRAP: tick_wrap = val[48:0];
        REG_USEC_TICK: usec_per_tick = val[47:0];
        REG_RATE_ERR:  rate_err = val[31:0];
        default:       reset_us = val[39:0];
      endcase
    endfunction

    // floor(a*b / 2^32), capped at 2^62-1
    function logic [63:0] scale_sat(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = ({64'd0, a} * {64'd0, b}) >> 32;
      return (prod > {64'd0, MAG_SAT}) ? MAG_SAT : prod[63:0];
    endfunction

    // signed usec span from the anchor to an unwrapped tick count
    function longint ticks_to_us(logic [63:0] target);
      logic [63:0] d, mag;
      longint v;
      d = target - anchor_ticks;
      mag = d[63] ? -d : d;
      v = longint'(scale_sat(mag, {16'd0, usec_per_tick}));
      return d[63] ? -v : v;
    endfunction

    function logic [63:0] slack(longint dp);
      logic [63:0] mag;
      mag = (dp < 0) ? -dp : dp;
      return scale_sat(mag, {32'd0, rate_err});
    endfunction

    function longint sat_sum(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return longint'(s);
    endfunction

    function void note_request(logic [1:0] func, logic [62:0] host, logic [47:0] ticks);
      sync_result_t r;
      logic [63:0] pi, err;
      longint dp, dq, e;
      r = '0;
      if (func == FUNC_UPDATE) begin
        if (ticks < last_ticks) tick_offset += {15'd0, tick_wrap};
        last_ticks = ticks;
        pi = tick_offset + ticks;
        if (!anchored) begin
          anchor_ticks = pi;
          anchor_host = host;
          anchored = 1;
          r.status = ST_RESYNC;
        end else begin
          dp = ticks_to_us(pi);
          dq = longint'({1'b0, host}) - longint'(anchor_host);
          err = (dp >= dq) ? dp - dq : dq - dp;
          r.sync_err = (err > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : err[31:0];
          if (err >= {24'd0, reset_us}) begin
            anchor_ticks = pi;
            anchor_host = host;
            r.status = ST_RESYNC;
          end else if (dp + longint'(slack(dp)) >= dq) begin
            anchor_ticks = pi;
            anchor_host = host;
          end
        end
      end else if (func == FUNC_QUERY) begin
        if (!anchored) r.status = ST_NOREF;
        else begin
          pi = tick_offset + ticks;
          // newer than the last update: belongs to the previous epoch
          if (ticks > last_ticks) pi -= {15'd0, tick_wrap};
          dp = ticks_to_us(pi);
          e = sat_sum(longint'(anchor_host), dp);
          e = sat_sum(e, longint'(slack(dp)));
          r.host_est = e;
        end
      end else if (func == FUNC_CLEAR) anchored = 0;
      due_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      sync_result_t exp_r;
      if (due_q.size() == 0) begin
        $error("result with nothing outstanding: %h", data);
        errors++;
        return;
      end
      exp_r = due_q.pop_front();
      if (data[1:0] !== exp_r.status) begin
        $error("status exp %0d got %0d", exp_r.status, data[1:0]);
        errors++;
      end
      if (data[65:2] !== exp_r.host_est) begin
        $error("host_estimate exp %0d got %0d", $signed(exp_r.host_est),
               $signed(data[65:2]));
        errors++;
      end
      if (data[97:66] !== exp_r.sync_err) begin
        $error("sync_error exp %0d got %0d", exp_r.sync_err, data[97:66]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic [119:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  passive_clock_sync_tracker DUT (.*);

  sync_scoreboard sb = new();

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #60ms;
    $display("FAIL");
    $finish;
  end

  // Result side: ready follows a pattern of its own, alternating between
  // windows of heavy stalling, light stalling and none at all.
  int unsigned rx_cycle = 0;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle >> 9) % 3)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // sender burst state
  int burst_left = 0;
  // stream position for well-formed sequences
  logic [47:0] cur_ticks;
  logic [62:0] cur_host;

  // Present one request and hold it until taken; called on a clock edge.
  task automatic send_request(logic [1:0] func, logic [62:0] host, logic [47:0] ticks);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, ticks, host, func};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(func, host, ticks);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 40) : 1) @(posedge clk_i);
    end
  endtask

  // APB write, only once the block has drained
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    s_axis_tvalid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    // a query or clear may still be in flight behind the last result
    repeat (120) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One random request: mostly consistent update/query streams,
  // the rest clears and raw noise.
  task automatic random_request();
    logic [63:0] span, step, host_step;
    int pick;
    span = (sb.tick_wrap > 49'h1_0000_0000_0000) ? 64'h1_0000_0000_0000
                                                  : {15'd0, sb.tick_wrap};
    pick = $urandom_range(0, 99);
    step = $urandom_range(1, 5000);
    if (pick < 60) begin
      cur_ticks = ({16'd0, cur_ticks} + step) % span;
      host_step = (step * sb.usec_per_tick) >> 32;
      cur_host = cur_host + host_step[62:0] + $urandom_range(0, 200);
      if ($urandom_range(0, 15) == 0) cur_host = cur_host - $urandom_range(0, 400);
      send_request(FUNC_UPDATE, cur_host, cur_ticks);
    end else if (pick < 85) begin
      send_request(FUNC_QUERY, 63'd0,
                   $urandom_range(0, 3) == 0 ? cur_ticks + $urandom_range(1, 99)
                                             : cur_ticks - $urandom_range(0, 3000));
    end else if (pick < 90) send_request(FUNC_CLEAR, rand64(), rand64());
    else send_request(2'($urandom_range(0, 3)), rand64(), rand64());
  endtask

  initial begin
    logic [63:0] wraps[4];
    logic [63:0] upts[4];
    logic [63:0] rates[4];
    logic [63:0] resets[4];
    sb.restart();
    cur_ticks = '0;
    cur_host = 63'd1000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no reference, odd func code, first update, extremes
    send_request(FUNC_QUERY, 63'd5, 48'd7);
    send_request(2'd3, '1, '1);
    send_request(FUNC_UPDATE, 63'd1000, 48'd0);
    send_request(FUNC_QUERY, 63'd0, 48'd0);
    send_request(FUNC_UPDATE, 63'd2000, 48'd1000);
    send_request(FUNC_UPDATE, 63'd2990, 48'd2000);
    send_request(FUNC_UPDATE, '1, 48'd3000);
    send_request(FUNC_QUERY, 63'd0, 48'd3500);
    send_request(FUNC_UPDATE, 63'd0, '1);
    send_request(FUNC_UPDATE, 63'd10, 48'd5);
    send_request(FUNC_QUERY, 63'd0, '1);
    send_request(FUNC_QUERY, 63'd0, 48'd0);
    send_request(FUNC_CLEAR, 63'd0, 48'd0);
    send_request(FUNC_QUERY, 63'd0, 48'd1);
    send_request(FUNC_UPDATE, 63'd1000, 48'd100);
    write_reg(REG_USEC_TICK, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_RATE_ERR, 64'hFFFF_FFFF);
    // huge spans: magnitude and estimate saturation
    send_request(FUNC_QUERY, 63'd0, '1);
    send_request(FUNC_UPDATE, '1, 48'h8000_0000);
    send_request(FUNC_QUERY, 63'd0, 48'd0);
    send_request(FUNC_QUERY, 63'd0, 48'hFFFF_FFFF);

    wraps = '{64'h1_0000_0000_0000, 64'd1, 64'h1_0000_0000, 64'd4096};
    upts = '{64'd1, 64'hFFFF_FFFF_FFFF, 64'h1_0000_0000, 64'h8000_0000};
    rates = '{64'd0, 64'hFFFF_FFFF, 64'd429497, 64'd1 << 24};
    resets = '{64'd0, 64'hFF_FFFF_FFFF, 64'd500000, 64'd2000};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 4) begin
        write_reg(REG_TICK_WRAP, wraps[ph]);
        write_reg(REG_USEC_TICK, upts[ph]);
        write_reg(REG_RATE_ERR, rates[ph]);
        write_reg(REG_RESET_US, resets[ph]);
      end else begin
        write_reg(REG_TICK_WRAP, wraps[$urandom_range(0, 3)]);
        write_reg(REG_USEC_TICK, upts[$urandom_range(0, 3)] | $urandom_range(0, 255));
        write_reg(REG_RATE_ERR, $urandom_range(0, 3) == 0 ? rates[1] : $urandom_range(0, 1 << 26));
        write_reg(REG_RESET_US, resets[$urandom_range(0, 3)]);
      end
      @(posedge clk_i);
      cur_ticks = '0;
      repeat (155) random_request();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

@@ passive_clock_sync_tracker.f @@
hdl/pcst_pkg.sv
hdl/passive_clock_sync_tracker.sv
tb/sv/tb_passive_clock_sync_tracker.sv
